### rtl/afcc_pkg.sv
// Shared types, character codes and CRC/hex helper functions for the
// ASCII frame CRC-32 checker. No dependencies.
`timescale 1ns / 1ps

package afcc_pkg;

  localparam logic [7:0]  CharHash    = 8'h23;
  localparam logic [7:0]  CharStar    = 8'h2A;
  localparam logic [7:0]  CharCr      = 8'h0D;
  localparam logic [7:0]  CharLf      = 8'h0A;
  localparam logic [31:0] CrcPoly     = 32'hEDB88320;
  localparam logic [3:0]  HexFieldLen = 4'd8;
  localparam logic [15:0] MaxLenReset = 16'd1024;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMismatch = 2'd1,
    StNoField  = 2'd2,
    StBadHex   = 2'd3
  } status_e;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] computed_crc;
    logic [31:0] received_crc;
    logic [15:0] frame_length;
  } afcc_result_t;

  typedef logic [31:0] crc_tbl_t [256];

  function automatic crc_tbl_t crc_gen_table();
    crc_tbl_t    tbl;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      tbl[i] = c;
    end
    return tbl;
  endfunction

  // entry 1 is 0x77073096
  localparam crc_tbl_t CrcTable = crc_gen_table();

  function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
    logic [7:0] idx;
    idx = crc[7:0] ^ b;
    return (crc >> 8) ^ CrcTable[idx];
  endfunction

  // bit 4 set marks a non-hex character
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c inside {[8'h30:8'h39]}) d = {1'b0, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) d = {1'b0, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) d = {1'b0, 4'(c - 8'h37)};
    return d;
  endfunction

endpackage

### rtl/afcc_frame_engine.sv
// Frame state, running CRC-32 and checksum field parser; one byte per step.
// Depends on afcc_pkg.
`timescale 1ns / 1ps

module afcc_frame_engine import afcc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  input  logic [15:0]  max_len_i,
  output afcc_result_t res_o
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] len_q, len_d;
  logic        star_q, star_d;
  logic [31:0] crc_q, crc_d;
  logic [3:0]  hex_cnt_q, hex_cnt_d;
  logic [31:0] hex_val_q, hex_val_d;
  logic        hex_stop_q, hex_stop_d;
  logic        hex_bad_q, hex_bad_d;
  logic [4:0]  digit;

  assign digit = hex_digit(byte_i);

  always_comb begin
    in_frame_d = in_frame_q;
    len_d      = len_q;
    star_d     = star_q;
    crc_d      = crc_q;
    hex_cnt_d  = hex_cnt_q;
    hex_val_d  = hex_val_q;
    hex_stop_d = hex_stop_q;
    hex_bad_d  = hex_bad_q;
    res_o      = '0;

    res_o.computed_crc = crc_q;
    res_o.received_crc = hex_val_q;
    res_o.frame_length = len_q;
    if (!star_q || hex_cnt_q < HexFieldLen) begin
      res_o.status       = StNoField;
      res_o.received_crc = '0;
    end else if (hex_bad_q) begin
      res_o.status = StBadHex;
    end else if (crc_q == hex_val_q) begin
      res_o.status = StOk;
    end else begin
      res_o.status = StMismatch;
    end

    if (byte_i == CharHash || byte_i == CharCr || byte_i == CharLf) begin
      res_o.valid = (byte_i != CharHash) && in_frame_q;
      in_frame_d  = (byte_i == CharHash);
      len_d       = (byte_i == CharHash) ? 16'd1 : 16'd0;
      star_d      = 1'b0;
      crc_d       = '0;
      hex_cnt_d   = '0;
      hex_val_d   = '0;
      hex_stop_d  = 1'b0;
      hex_bad_d   = 1'b0;
    end else if (in_frame_q) begin
      if (len_q >= max_len_i) begin
        in_frame_d = 1'b0;
        len_d      = '0;
        star_d     = 1'b0;
        crc_d      = '0;
        hex_cnt_d  = '0;
        hex_val_d  = '0;
        hex_stop_d = 1'b0;
        hex_bad_d  = 1'b0;
      end else begin
        len_d = len_q + 16'd1;
        if (!star_q) begin
          if (byte_i == CharStar) star_d = 1'b1;
          else crc_d = crc_update(crc_q, byte_i);
        end else if (hex_cnt_q < HexFieldLen) begin
          if (!hex_stop_q) begin
            if (!digit[4]) begin
              hex_val_d = {hex_val_q[27:0], digit[3:0]};
            end else begin
              hex_stop_d = 1'b1;
              hex_bad_d  = (hex_cnt_q == '0);
            end
          end
          hex_cnt_d = hex_cnt_q + 4'd1;
        end
      end
    end

    if (!step_i) res_o.valid = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
      star_q     <= 1'b0;
      crc_q      <= '0;
      hex_cnt_q  <= '0;
      hex_val_q  <= '0;
      hex_stop_q <= 1'b0;
      hex_bad_q  <= 1'b0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      star_q     <= star_d;
      crc_q      <= crc_d;
      hex_cnt_q  <= hex_cnt_d;
      hex_val_q  <= hex_val_d;
      hex_stop_q <= hex_stop_d;
      hex_bad_q  <= hex_bad_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_cnt_q <= HexFieldLen) else $error("hex count past field length");
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (len_q == '0 && !star_q && crc_q == '0))
    else $error("frame state left over outside a frame");
  a_star_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !star_q |-> (hex_cnt_q == '0 && !hex_stop_q))
    else $error("checksum field parsed before star");
  a_bad_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_bad_q |-> hex_stop_q) else $error("bad first digit without stop");
  a_res_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (in_frame_q && step_i)) else $error("result outside frame");

endmodule

### rtl/ascii_frame_crc32_checker.sv
// Top level of the ASCII frame CRC-32 checker: stream handshakes, input and
// result registers, max frame length register. Depends on afcc_pkg and
// afcc_frame_engine.
//
// Takes one byte word per clock on s_axis. A '#' opens a frame, CR or LF
// closes it and produces one result word on m_axis: tuser carries the
// status, tdata the computed CRC (reflected CRC-32, poly 0xEDB88320, zero
// init, no final XOR), the received checksum and the frame length. A byte
// is accepted every cycle while results are taken; a result is formed while
// its terminator sits in the input register, with the status and both
// checksums formed into the result register. While a result waits unread,
// the input register holds and s_axis stalls once it is full. Frames longer
// than the configured length are dropped with no result. The length limit
// resets to 1024; the user must write it through cfg only while the block
// is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps

module ascii_frame_crc32_checker import afcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,       // max_frame_len
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [31:0] computed_crc, [63:32] received_crc,
                                        // [79:64] frame_length
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  logic         in_vld_q, in_vld_d;
  logic [7:0]   in_byte_q;
  logic         out_vld_q, out_vld_d;
  logic [79:0]  out_data_q;
  logic [1:0]   out_user_q;
  logic [15:0]  max_len_q;
  logic         adv;
  logic         step;
  afcc_result_t res;

  assign cfg_ready_o     = 1'b1;
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && adv;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign in_vld_d        = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;
  assign out_vld_d       = adv ? res.valid : out_vld_q;

  afcc_frame_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      max_len_q <= MaxLenReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_byte_q <= s_axis_tdata_i;
    if (adv && res.valid) begin
      out_data_q <= {res.frame_length, res.received_crc, res.computed_crc};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
